// File: sv/hsd_pkg.sv
// Shared widths, constants and types of the haversine distance pipeline.
package hsd_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 16;

	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int KM_W  = 15;

	// Q30 fixed point: angles, sines, cosines, roots
	localparam int QW = 31;
	typedef logic [QW-1:0] q30_t;
	localparam q30_t Q_ONE = 31'h4000_0000;

	localparam int HALF_TURN_DEG   = 180;
	localparam int EARTH_RADIUS_KM = 6371;
	localparam int CENTRAL_FACTOR  = 2;
	localparam logic [KM_W-1:0] MAX_KM = 15'd20015;

	// round(pi/180 * 2^46) and round(pi/2 * 2^30)
	localparam logic [40:0] DEG_TO_RAD_Q46 = 41'd1228166276394;
	localparam q30_t HALF_PI_Q30 = 31'd1686629713;

	localparam int SERIES_TERMS = 8;
	// x squared, three stages per term, final clamp
	localparam int SERIES_LAT = 3 * SERIES_TERMS + 2;

	// the bracket of width HALF_PI_Q30 shrinks to one after 31 halvings
	localparam int BISECT_STEPS = 31;

	typedef struct packed {
		q30_t lo;
		q30_t hi;
		q30_t y;
		q30_t x;
	} bis_t;

endpackage

// File: sv/hsd_angle.sv
// Input clamping, angle differences and degree to Q30 radian conversion.
module hsd_angle #(
	parameter int ANGLE_FRAC_BITS = hsd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic signed [hsd_pkg::LAT_W-1:0] start_lat,
	input  logic signed [hsd_pkg::LON_W-1:0] start_lon,
	input  logic signed [hsd_pkg::LAT_W-1:0] end_lat,
	input  logic signed [hsd_pkg::LON_W-1:0] end_lon,
	output logic                             out_vld,
	output hsd_pkg::q30_t                    dlat_rad,
	output hsd_pkg::q30_t                    dlon_rad,
	output hsd_pkg::q30_t                    lat1_rad,
	output hsd_pkg::q30_t                    lat2_rad
);
	import hsd_pkg::*;

	localparam int F  = ANGLE_FRAC_BITS;
	localparam int CW = (F + 10 > LON_W + 1) ? F + 10 : LON_W + 1;
	localparam int DW = CW - 1;
	localparam logic signed [CW-1:0] LAT_LIM = CW'(HALF_TURN_DEG / 2) << F;
	localparam logic signed [CW-1:0] LON_LIM = CW'(HALF_TURN_DEG) << F;
	localparam logic [8:0]  K_HI = 9'(DEG_TO_RAD_Q46 >> 32);
	localparam logic [31:0] K_LO = DEG_TO_RAD_Q46[31:0];

	function automatic logic signed [CW-1:0] clamp_sym(
		input logic signed [CW-1:0] v,
		input logic signed [CW-1:0] lim
	);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] n;
		n = -v;
		return v[CW-1] ? n[DW-1:0] : v[DW-1:0];
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [CW-1:0] la1_s1, lo1_s1, la2_s1, lo2_s1;
	logic [DW-1:0] dlat_s2, dlon_s2, ala1_s2, ala2_s2;
	logic [DW-1:0] d_s3 [4];
	logic [DW+8:0]  ph_s4 [4];
	logic [DW+31:0] pl_s4 [4];
	q30_t rad_s5 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			la1_s1 <= clamp_sym(CW'(start_lat), LAT_LIM);
			lo1_s1 <= clamp_sym(CW'(start_lon), LON_LIM);
			la2_s1 <= clamp_sym(CW'(end_lat), LAT_LIM);
			lo2_s1 <= clamp_sym(CW'(end_lon), LON_LIM);

			dlat_s2 <= mag(la2_s1 - la1_s1);
			dlon_s2 <= mag(lo2_s1 - lo1_s1);
			ala1_s2 <= mag(la1_s1);
			ala2_s2 <= mag(la2_s1);

			d_s3[0] <= dlat_s2;
			// go the shorter way round
			if (dlon_s2 > DW'(LON_LIM))
				d_s3[1] <= DW'(LON_LIM) + DW'(LON_LIM) - dlon_s2;
			else
				d_s3[1] <= dlon_s2;
			d_s3[2] <= ala1_s2;
			d_s3[3] <= ala2_s2;
		end
	end

	// differences give the half angle, latitudes the full angle
	for (genvar i = 0; i < 4; i++) begin : g_lane
		localparam int S = (i < 2) ? F + 17 : F + 16;
		logic [DW+41:0] tot;
		logic [DW+41:0] sh;

		assign tot = {1'b0, ph_s4[i], 32'b0} + (DW+42)'(pl_s4[i]);
		assign sh  = tot >> S;

		always_ff @(posedge clk) begin
			if (en) begin
				ph_s4[i]  <= d_s3[i] * K_HI;
				pl_s4[i]  <= d_s3[i] * K_LO;
				rad_s5[i] <= sh[QW-1:0];
			end
		end
	end

	assign out_vld  = vld_s5;
	assign dlat_rad = rad_s5[0];
	assign dlon_rad = rad_s5[1];
	assign lat1_rad = rad_s5[2];
	assign lat2_rad = rad_s5[3];

endmodule

// File: sv/hsd_series.sv
// Pipelined eight-term Taylor series for sine or cosine on [0, pi/2], Q30.
module hsd_series #(
	parameter bit IS_COS = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  hsd_pkg::q30_t ang,
	output logic          out_vld,
	output hsd_pkg::q30_t res
);
	import hsd_pkg::*;

	localparam int NT = SERIES_TERMS;
	localparam int TW = 32;
	localparam int SW = 35;

	logic [2*QW-1:0] sq;

	// index 0 holds the seed after the x squared stage
	logic [TW-1:0]        term_s4 [0:NT];
	logic signed [SW-1:0] sum_s4  [0:NT];
	logic [TW-1:0]        x2_s4   [0:NT];
	logic                 vld_s4  [0:NT];

	logic [TW-1:0]        n_s2   [1:NT];
	logic signed [SW-1:0] sum_s2 [1:NT];
	logic [TW-1:0]        x2_s2  [1:NT];
	logic                 vld_s2 [1:NT];

	logic [TW-1:0]        q0_s3  [1:NT];
	logic [TW-1:0]        n_s3   [1:NT];
	logic signed [SW-1:0] sum_s3 [1:NT];
	logic [TW-1:0]        x2_s3  [1:NT];
	logic                 vld_s3 [1:NT];

	logic                 vld_s5;
	q30_t                 res_s5;

	assign sq = ang * ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4[0] <= 1'b0;
		else if (en) vld_s4[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s4[0]   <= sq[30 +: TW];
			term_s4[0] <= IS_COS ? TW'(Q_ONE) : TW'(ang);
			sum_s4[0]  <= IS_COS ? SW'(Q_ONE) : SW'(ang);
		end
	end

	for (genvar k = 1; k <= NT; k++) begin : g_term
		localparam int C = IS_COS ? (2 * k - 1) * (2 * k) : (2 * k) * (2 * k + 1);
		localparam int L = $clog2(C + 1) - 1;
		localparam int K = 32 + L;
		// reciprocal of C; quotient comes out at most one short
		localparam logic [32:0] M  = 33'((65'd1 << K) / C);
		localparam logic [8:0]  CV = 9'(C);

		logic [2*TW-1:0] p;
		logic [TW+32:0]  pm;
		logic [TW+32:0]  pm_sh;
		logic [TW+8:0]   qc;
		logic [TW-1:0]   rm;
		logic [TW-1:0]   q;

		assign p     = term_s4[k-1] * x2_s4[k-1];
		assign pm    = n_s2[k] * M;
		assign pm_sh = pm >> K;
		assign qc    = q0_s3[k] * CV;
		assign rm    = n_s3[k] - qc[TW-1:0];
		assign q     = (rm >= TW'(C)) ? q0_s3[k] + 1'b1 : q0_s3[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
				vld_s3[k] <= 1'b0;
				vld_s4[k] <= 1'b0;
			end else if (en) begin
				vld_s2[k] <= vld_s4[k-1];
				vld_s3[k] <= vld_s2[k];
				vld_s4[k] <= vld_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s2[k]   <= p[30 +: TW];
				sum_s2[k] <= sum_s4[k-1];
				x2_s2[k]  <= x2_s4[k-1];

				q0_s3[k]  <= pm_sh[TW-1:0];
				n_s3[k]   <= n_s2[k];
				sum_s3[k] <= sum_s2[k];
				x2_s3[k]  <= x2_s2[k];

				term_s4[k] <= q;
				x2_s4[k]   <= x2_s3[k];
				if (k % 2 == 1) sum_s4[k] <= sum_s3[k] - SW'(q);
				else sum_s4[k] <= sum_s3[k] + SW'(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4[NT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum_s4[NT][SW-1]) res_s5 <= '0;
			else if (sum_s4[NT] > SW'(Q_ONE)) res_s5 <= Q_ONE;
			else res_s5 <= sum_s4[NT][QW-1:0];
		end
	end

	assign out_vld = vld_s5;
	assign res     = res_s5;

endmodule

// File: sv/hsd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module hsd_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [2*hsd_pkg::QW-1:0]  v,
	output logic                      out_vld,
	output hsd_pkg::q30_t             root
);
	import hsd_pkg::*;

	localparam int RW = QW + 4;

	logic [RW-1:0]   rem_s  [0:QW];
	logic [QW-1:0]   root_s [0:QW];
	logic [2*QW-1:0] v_s    [0:QW];
	logic            vld_s  [0:QW];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign v_s[0]    = v;
	assign vld_s[0]  = in_vld;

	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int P = QW - 1 - i;
		logic [RW-1:0] ra;
		logic [RW-1:0] tr;

		assign ra = {rem_s[i][RW-3:0], v_s[i][2*P+1 -: 2]};
		assign tr = RW'({root_s[i], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else if (en) vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i+1] <= v_s[i];
				if (ra >= tr) begin
					rem_s[i+1]  <= ra - tr;
					root_s[i+1] <= {root_s[i][QW-2:0], 1'b1};
				end else begin
					rem_s[i+1]  <= ra;
					root_s[i+1] <= {root_s[i][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign root    = root_s[QW];

endmodule

// File: sv/hsd_bisect.sv
// One bisection step of the arctangent: halves the bracket on sign of y*cos - x*sin.
module hsd_bisect (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  hsd_pkg::bis_t in_st,
	output logic          out_vld,
	output hsd_pkg::bis_t out_st
);
	import hsd_pkg::*;

	localparam int DL = SERIES_LAT;

	typedef struct packed {
		bis_t st;
		q30_t mid;
		logic act;
	} carry_t;

	logic [QW:0]     msum;
	carry_t          car_s1;
	logic            vld_s1;
	carry_t          dly_q [DL];
	q30_t            sin_v, cos_v;
	logic            sin_vld, cos_vld;
	logic [2*QW-1:0] py_s3, px_s3;
	carry_t          car_s3;
	logic            vld_s3;
	bis_t            st_s4;
	logic            vld_s4;

	assign msum = {1'b0, in_st.lo} + {1'b0, in_st.hi};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s3 <= sin_vld & cos_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s1.st  <= in_st;
			car_s1.mid <= msum[QW:1];
			// once the bracket is down to one the search stands still
			car_s1.act <= (in_st.hi - in_st.lo) > q30_t'(1);

			dly_q[0] <= car_s1;
			for (int i = 1; i < DL; i++) dly_q[i] <= dly_q[i-1];

			py_s3  <= dly_q[DL-1].st.y * cos_v;
			px_s3  <= dly_q[DL-1].st.x * sin_v;
			car_s3 <= dly_q[DL-1];

			st_s4.y <= car_s3.st.y;
			st_s4.x <= car_s3.st.x;
			if (car_s3.act && (py_s3 > px_s3)) st_s4.lo <= car_s3.mid;
			else st_s4.lo <= car_s3.st.lo;
			if (car_s3.act && !(py_s3 > px_s3)) st_s4.hi <= car_s3.mid;
			else st_s4.hi <= car_s3.st.hi;
		end
	end

	hsd_series #(.IS_COS(1'b0)) u_sin (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.ang     (car_s1.mid),
		.out_vld (sin_vld),
		.res     (sin_v)
	);

	hsd_series #(.IS_COS(1'b1)) u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.ang     (car_s1.mid),
		.out_vld (cos_vld),
		.res     (cos_v)
	);

	assign out_vld = vld_s4;
	assign out_st  = st_s4;

endmodule

// File: sv/haversine_distance.sv
// Top level: great-circle distance in whole km between two points, haversine formula.
//
//  channel   direction  handshake                words
//  pair      in         pair_valid / pair_ready  start_lat, start_lon, end_lat, end_lon
//  dist      out        dist_valid / dist_ready  distance_km
//
// One word accepted per cycle while pair_ready is high; 966 register stages, the first
// loaded by the accepting edge. The 31 arctangent bisection steps, each with its own
// sine and cosine, make up most of those stages.
// Reset clears only valid bits; no clearing pass, no state between words.
// A stalled output register freezes the whole pipeline; nothing is lost or repeated.
module haversine_distance #(
	parameter int ANGLE_FRAC_BITS = hsd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pair_valid,
	output logic                             pair_ready,
	input  logic signed [hsd_pkg::LAT_W-1:0] start_lat,
	input  logic signed [hsd_pkg::LON_W-1:0] start_lon,
	input  logic signed [hsd_pkg::LAT_W-1:0] end_lat,
	input  logic signed [hsd_pkg::LON_W-1:0] end_lon,
	output logic                             dist_valid,
	input  logic                             dist_ready,
	output logic [hsd_pkg::KM_W-1:0]         distance_km
);
	import hsd_pkg::*;

	localparam logic [13:0] CENTRAL_KM = 14'(CENTRAL_FACTOR * EARTH_RADIUS_KM);

	logic en;

	logic ang_vld;
	q30_t dlat_rad, dlon_rad, lat1_rad, lat2_rad;

	logic [3:0] trig_vld;
	q30_t s1, s2, c1, c2;

	logic [2*QW-1:0] p_sq1, p_sq2, p_cc, p_t;
	q30_t sq1_s1, sq2_s1, cc_s1;
	q30_t sq1_s2, t_s2;
	logic [QW:0] asum;
	q30_t a_s3;
	logic hvld_s1, hvld_s2, hvld_s3;

	logic [2*QW-1:0] vy, vx;
	logic sy_vld, sx_vld;
	q30_t ry, rx;

	bis_t bst  [0:BISECT_STEPS];
	logic bvld [0:BISECT_STEPS];

	logic [QW+13:0] dprod_s1;
	logic [QW+13:0] dsh;
	logic           dvld_s1;

	assign en         = ~dist_valid | dist_ready;
	assign pair_ready = en;

	hsd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (pair_valid),
		.start_lat (start_lat),
		.start_lon (start_lon),
		.end_lat   (end_lat),
		.end_lon   (end_lon),
		.out_vld   (ang_vld),
		.dlat_rad  (dlat_rad),
		.dlon_rad  (dlon_rad),
		.lat1_rad  (lat1_rad),
		.lat2_rad  (lat2_rad)
	);

	hsd_series #(.IS_COS(1'b0)) u_sin_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(ang_vld),
		.ang(dlat_rad), .out_vld(trig_vld[0]), .res(s1)
	);

	hsd_series #(.IS_COS(1'b0)) u_sin_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(ang_vld),
		.ang(dlon_rad), .out_vld(trig_vld[1]), .res(s2)
	);

	hsd_series #(.IS_COS(1'b1)) u_cos_lat1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(ang_vld),
		.ang(lat1_rad), .out_vld(trig_vld[2]), .res(c1)
	);

	hsd_series #(.IS_COS(1'b1)) u_cos_lat2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(ang_vld),
		.ang(lat2_rad), .out_vld(trig_vld[3]), .res(c2)
	);

	// haversine term a = sin^2(dlat/2) + cos lat1 cos lat2 sin^2(dlon/2)
	assign p_sq1 = s1 * s1;
	assign p_sq2 = s2 * s2;
	assign p_cc  = c1 * c2;
	assign p_t   = cc_s1 * sq2_s1;
	assign asum  = {1'b0, sq1_s2} + {1'b0, t_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvld_s1 <= 1'b0;
			hvld_s2 <= 1'b0;
			hvld_s3 <= 1'b0;
		end else if (en) begin
			hvld_s1 <= &trig_vld;
			hvld_s2 <= hvld_s1;
			hvld_s3 <= hvld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s1 <= p_sq1[30 +: QW];
			sq2_s1 <= p_sq2[30 +: QW];
			cc_s1  <= p_cc[30 +: QW];
			sq1_s2 <= sq1_s1;
			t_s2   <= p_t[30 +: QW];
			if (asum > {1'b0, Q_ONE}) a_s3 <= Q_ONE;
			else a_s3 <= asum[QW-1:0];
		end
	end

	assign vy = {1'b0, a_s3, 30'b0};
	assign vx = {1'b0, Q_ONE - a_s3, 30'b0};

	hsd_isqrt u_sqrt_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(hvld_s3),
		.v(vy), .out_vld(sy_vld), .root(ry)
	);

	hsd_isqrt u_sqrt_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(hvld_s3),
		.v(vx), .out_vld(sx_vld), .root(rx)
	);

	assign bst[0].lo = '0;
	assign bst[0].hi = HALF_PI_Q30;
	assign bst[0].y  = ry;
	assign bst[0].x  = rx;
	assign bvld[0]   = sy_vld & sx_vld;

	for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_step
		hsd_bisect u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (bvld[i]),
			.in_st   (bst[i]),
			.out_vld (bvld[i+1]),
			.out_st  (bst[i+1])
		);
	end

	// lower bound of the bracket is the half central angle
	assign dsh = dprod_s1 >> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s1    <= 1'b0;
			dist_valid <= 1'b0;
		end else if (en) begin
			dvld_s1    <= bvld[BISECT_STEPS];
			dist_valid <= dvld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s1 <= bst[BISECT_STEPS].lo * CENTRAL_KM;
			if (dsh > (QW+14)'(MAX_KM)) distance_km <= MAX_KM;
			else distance_km <= dsh[KM_W-1:0];
		end
	end

endmodule

// File: sv/hsd_checker.sv
// Port-level checks on the haversine distance block, bound to its top level.
module hsd_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     pair_valid,
	input logic                     pair_ready,
	input logic                     dist_valid,
	input logic                     dist_ready,
	input logic [hsd_pkg::KM_W-1:0] distance_km
);
	import hsd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && !dist_ready |=> dist_valid && $stable(distance_km))
		else $error("result word changed or dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid |-> distance_km <= MAX_KM)
		else $error("distance beyond half circumference");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pair_ready == (!dist_valid || dist_ready))
		else $error("input ready does not follow output stall");

endmodule

bind haversine_distance hsd_checker u_hsd_checker (.*);
